// ----- hdl/npc_pkg.sv -----
// Shared constants, palette table, reciprocal table and candidate type for the palette matcher.
`default_nettype none

package npc_pkg;

  localparam int FRAC_BITS = 10;
  localparam int NUM_COLORS = 9;

  localparam int CW   = 8;              // input channel width
  localparam int NW   = FRAC_BITS + 1;  // normalized channel width, full scale included
  localparam int FULL = 1 << FRAC_BITS;
  localparam int KW   = CW + FRAC_BITS; // reciprocal scale exponent
  localparam int RW   = KW + 1;         // reciprocal width
  localparam int PW   = CW + RW;        // channel times reciprocal
  localparam int QMW  = NW + CW;        // quotient estimate times max
  localparam int SQW  = 2 * NW;         // one squared channel difference
  localparam int DW   = SQW + 2;        // sum of three squares
  localparam int IW   = 4;              // color index width
  localparam int BDW  = 22;             // reported distance width
  localparam int CMPW = (DW > BDW) ? DW : BDW;
  localparam longint DIST_MAX = (64'd1 << BDW) - 64'd1;
  localparam longint DIST_TOP = 64'd3 << (2 * FRAC_BITS);
  localparam longint DIST_BOUND = (DIST_TOP < DIST_MAX) ? DIST_TOP : DIST_MAX;

  typedef logic [NW-1:0] pal_row_t [3];
  typedef pal_row_t pal_tbl_t [NUM_COLORS];

  // Palette entries scaled so that each entry's largest channel is full scale.
  localparam pal_tbl_t PAL_N = '{
    '{NW'((255 * FULL) / 255), NW'((40 * FULL) / 255),  NW'((28 * FULL) / 255)},
    '{NW'((117 * FULL) / 204), NW'((204 * FULL) / 204), NW'((38 * FULL) / 204)},
    '{NW'((0 * FULL) / 168),   NW'((68 * FULL) / 168),  NW'((168 * FULL) / 168)},
    '{NW'((255 * FULL) / 255), NW'((237 * FULL) / 255), NW'((0 * FULL) / 255)},
    '{NW'((170 * FULL) / 170), NW'((127 * FULL) / 170), NW'((170 * FULL) / 170)},
    '{NW'((178 * FULL) / 178), NW'((178 * FULL) / 178), NW'((178 * FULL) / 178)},
    '{NW'((249 * FULL) / 249), NW'((160 * FULL) / 249), NW'((28 * FULL) / 249)},
    '{NW'((130 * FULL) / 130), NW'((102 * FULL) / 130), NW'((71 * FULL) / 130)},
    '{NW'((255 * FULL) / 255), NW'((5 * FULL) / 255),   NW'((242 * FULL) / 255)}
  };

  typedef logic [RW-1:0] recip_tbl_t [256];

  // floor(2^KW / m) by restoring long division; evaluated at elaboration.
  function automatic recip_tbl_t build_recip();
    recip_tbl_t tbl;
    longint rem;
    logic [RW-1:0] quo;
    tbl[0] = '0;
    for (int m = 1; m < 256; m++) begin
      rem = 0;
      quo = '0;
      for (int i = KW; i >= 0; i--) begin
        rem = (rem << 1) | ((i == KW) ? 64'd1 : 64'd0);
        if (rem >= m) begin
          rem = rem - m;
          quo[i] = 1'b1;
        end
      end
      tbl[m] = quo;
    end
    return tbl;
  endfunction

  localparam recip_tbl_t RECIP_TBL = build_recip();

  typedef struct packed {
    logic [IW-1:0] idx;
    logic [DW-1:0] sqdist;
  } cand_t;

  // Keep the lower-index candidate a unless b is strictly nearer.
  function automatic cand_t pick(cand_t a, cand_t b);
    return (b.sqdist < a.sqdist) ? b : a;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/nearest_palette_color.sv -----
// Nearest palette color matcher: normalize the pixel, measure nine distances, pick the minimum.
// Throughput: one request per cycle; busy_o stays low and the result strobes for one cycle.
// The receiver cannot stall, so the pipeline never holds; each stage advances every cycle.
// The pixel divide is a reciprocal table lookup, a multiply and one correction step.
// Reset (rst_ni low, asynchronous) clears the valid bits only; data registers are not reset.
`default_nettype none

module nearest_palette_color import npc_pkg::*; (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start_i,
  output logic                busy_o,
  input  wire logic [CW-1:0]  red_i,
  input  wire logic [CW-1:0]  green_i,
  input  wire logic [CW-1:0]  blue_i,
  output logic                valid_o,
  output logic [IW-1:0]       color_index_o,
  output logic [BDW-1:0]      best_distance_o
);

  localparam int N_STG = 12;

  // Valid bits, one per stage; the last one drives valid_o.
  logic [N_STG-1:0] vld_q, vld_d;

  // Stage 1: channels and their maximum.
  logic [CW-1:0] chan_q1 [3];
  logic [CW-1:0] max_q1, max_d1;
  logic          zero_q1;

  // Stage 2: reciprocal of the maximum.
  logic [CW-1:0] chan_q2 [3];
  logic [CW-1:0] max_q2;
  logic          zero_q2;
  logic [RW-1:0] recip_q2;

  // Stage 3: channel times reciprocal.
  logic [CW-1:0] chan_q3 [3];
  logic [CW-1:0] max_q3;
  logic          zero_q3;
  logic [PW-1:0] prod_q3 [3];

  // Stage 4: quotient estimate and its back-multiplied value.
  logic [CW-1:0]  chan_q4 [3];
  logic [CW-1:0]  max_q4;
  logic           zero_q4;
  logic [NW-1:0]  quo_q4 [3], quo_d4 [3];
  logic [QMW-1:0] qm_q4 [3];

  // Stage 5: corrected normalized pixel.
  logic [NW-1:0] pix_q5 [3], pix_d5 [3];

  // Stages 6 to 8: differences, squares, distances.
  logic [NW-1:0]  diff_q6 [NUM_COLORS][3], diff_d6 [NUM_COLORS][3];
  logic [SQW-1:0] sq_q7 [NUM_COLORS][3];
  cand_t          cand_q8 [NUM_COLORS], cand_d8 [NUM_COLORS];

  // Stages 9 to 11: compare tree; stage 12: output.
  cand_t l1_q [5], l1_d [5];
  cand_t l2_q [3], l2_d [3];
  cand_t l3_q [2], l3_d [2];
  cand_t win_d;
  logic [BDW-1:0] dist_sat_d;

  // Never hold off a request: every stage advances each cycle.
  assign busy_o  = 1'b0;
  assign valid_o = vld_q[N_STG-1];

  assign vld_d = {vld_q[N_STG-2:0], start_i & ~busy_o};

  always_comb begin
    max_d1 = red_i;
    if (green_i > max_d1) max_d1 = green_i;
    if (blue_i > max_d1) max_d1 = blue_i;
  end

  // Estimate is floor(c*2^F/max) or one below; bump it when the remainder reaches max.
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      quo_d4[ch] = prod_q3[ch][CW+NW-1:CW];
      if (zero_q4) begin
        pix_d5[ch] = NW'(FULL);
      end else if ((QMW+1)'(qm_q4[ch]) + (QMW+1)'(max_q4)
                   <= (QMW+1)'({chan_q4[ch], {FRAC_BITS{1'b0}}})) begin
        pix_d5[ch] = quo_q4[ch] + NW'(1);
      end else begin
        pix_d5[ch] = quo_q4[ch];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_COLORS; k++) begin
      for (int ch = 0; ch < 3; ch++) begin
        diff_d6[k][ch] = (pix_q5[ch] > PAL_N[k][ch]) ? pix_q5[ch] - PAL_N[k][ch]
                                                     : PAL_N[k][ch] - pix_q5[ch];
      end
      cand_d8[k].idx    = IW'(k);
      cand_d8[k].sqdist = DW'(sq_q7[k][0]) + DW'(sq_q7[k][1]) + DW'(sq_q7[k][2]);
    end
  end

  // Pair lower indices on the left so ties keep the lower index.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      l1_d[i] = pick(cand_q8[2*i], cand_q8[2*i+1]);
    end
    l1_d[4] = cand_q8[8];
    l2_d[0] = pick(l1_q[0], l1_q[1]);
    l2_d[1] = pick(l1_q[2], l1_q[3]);
    l2_d[2] = l1_q[4];
    l3_d[0] = pick(l2_q[0], l2_q[1]);
    l3_d[1] = l2_q[2];
    win_d   = pick(l3_q[0], l3_q[1]);
    if (CMPW'(win_d.sqdist) > CMPW'(DIST_MAX)) begin
      dist_sat_d = BDW'(DIST_MAX);
    end else begin
      dist_sat_d = BDW'(win_d.sqdist);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chan_q1[0] <= red_i;
    chan_q1[1] <= green_i;
    chan_q1[2] <= blue_i;
    max_q1     <= max_d1;
    zero_q1    <= (max_d1 == '0);

    chan_q2  <= chan_q1;
    max_q2   <= max_q1;
    zero_q2  <= zero_q1;
    recip_q2 <= RECIP_TBL[max_q1];

    chan_q3 <= chan_q2;
    max_q3  <= max_q2;
    zero_q3 <= zero_q2;
    for (int ch = 0; ch < 3; ch++) begin
      prod_q3[ch] <= PW'(chan_q2[ch]) * PW'(recip_q2);
    end

    chan_q4 <= chan_q3;
    max_q4  <= max_q3;
    zero_q4 <= zero_q3;
    quo_q4  <= quo_d4;
    for (int ch = 0; ch < 3; ch++) begin
      qm_q4[ch] <= QMW'(quo_d4[ch]) * QMW'(max_q3);
    end

    pix_q5  <= pix_d5;
    diff_q6 <= diff_d6;
    for (int k = 0; k < NUM_COLORS; k++) begin
      for (int ch = 0; ch < 3; ch++) begin
        sq_q7[k][ch] <= SQW'(diff_q6[k][ch]) * SQW'(diff_q6[k][ch]);
      end
    end
    cand_q8 <= cand_d8;
    l1_q    <= l1_d;
    l2_q    <= l2_d;
    l3_q    <= l3_d;

    color_index_o   <= win_d.idx;
    best_distance_o <= dist_sat_d;
  end

  // Divider check: the largest normalized channel must land exactly on full scale.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] |-> (pix_q5[0] == NW'(FULL) || pix_q5[1] == NW'(FULL) || pix_q5[2] == NW'(FULL)))
    else $error("normalized pixel misses full scale");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[4] |-> (pix_q5[0] <= NW'(FULL) && pix_q5[1] <= NW'(FULL) && pix_q5[2] <= NW'(FULL)))
    else $error("normalized channel above full scale");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (color_index_o < IW'(NUM_COLORS) && 64'(best_distance_o) <= DIST_BOUND))
    else $error("result out of range");

endmodule

`default_nettype wire

// ----- bench/nearest_palette_color_test.sv -----
// Self-checking testbench for the nearest palette color matcher.
module nearest_palette_color_test;
  timeunit 1ns;
  timeprecision 1ps;

  import npc_pkg::*;

  // Scale of a normalized channel: full scale equals 2^FRAC_BITS.
  localparam longint UNIT = longint'(1) << FRAC_BITS;
  // Largest distance the result port can carry; larger ones saturate.
  localparam longint DIST_CEIL = (longint'(1) << BDW) - 1;
  // Pipeline depth from the accepting edge to the result strobe.
  localparam int PIPE_DEPTH = 12;
  // Palette as 8-bit RGB, before normalization.
  localparam logic [3*CW-1:0] SWATCH [NUM_COLORS] = '{
    24'hff281c, 24'h75cc26, 24'h0044a8, 24'hffed00, 24'haa7faa,
    24'hb2b2b2, 24'hf9a01c, 24'h826647, 24'hff05f2
  };

  typedef struct packed {
    logic [3*CW-1:0] pixel;
    logic [IW-1:0]   idx;
    logic [BDW-1:0]  sqdist;
  } color_match_t;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           start_i;
  logic           busy_o;
  logic [CW-1:0]  red_i;
  logic [CW-1:0]  green_i;
  logic [CW-1:0]  blue_i;
  logic           valid_o;
  logic [IW-1:0]  color_index_o;
  logic [BDW-1:0] best_distance_o;

  // Matches predicted for accepted pixels, oldest first.
  color_match_t pending_matches [$];

  int pixels_sent;
  int matches_seen;
  int mismatch_count;
  int tie_pixels;
  int color_wins [NUM_COLORS];

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  nearest_palette_color u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .red_i          (red_i),
    .green_i        (green_i),
    .blue_i         (blue_i),
    .valid_o        (valid_o),
    .color_index_o  (color_index_o),
    .best_distance_o(best_distance_o)
  );

  // Scale one channel so the pixel's largest channel lands on full scale.
  // A pixel with no light at all counts as white.
  function automatic longint scale_to_unit(input longint chan, input longint peak);
    if (peak == 0) return UNIT;
    return (chan * UNIT) / peak;
  endfunction

  // Predict the winning palette color and its squared distance. Flag a pixel
  // whose minimum is shared by two colors, where the lower index must win.
  function automatic color_match_t nearest_color(input logic [3*CW-1:0] pixel,
                                                 output bit tied);
    color_match_t    m;
    longint          px [3];
    longint          pc [3];
    longint          peak;
    longint          swatch_peak;
    longint          d;
    longint          best;
    longint          diff;
    int              win;
    logic [3*CW-1:0] rgb;
    peak = 0;
    for (int c = 0; c < 3; c++)
      if (longint'(pixel[3*CW-1-CW*c -: CW]) > peak)
        peak = longint'(pixel[3*CW-1-CW*c -: CW]);
    for (int c = 0; c < 3; c++)
      px[c] = scale_to_unit(longint'(pixel[3*CW-1-CW*c -: CW]), peak);
    best = 0;
    win = 0;
    tied = 1'b0;
    for (int k = 0; k < NUM_COLORS; k++) begin
      rgb = SWATCH[k];
      swatch_peak = 0;
      for (int c = 0; c < 3; c++)
        if (longint'(rgb[3*CW-1-CW*c -: CW]) > swatch_peak)
          swatch_peak = longint'(rgb[3*CW-1-CW*c -: CW]);
      d = 0;
      for (int c = 0; c < 3; c++) begin
        pc[c] = scale_to_unit(longint'(rgb[3*CW-1-CW*c -: CW]), swatch_peak);
        diff = px[c] - pc[c];
        d += diff * diff;
      end
      // Keep the earlier color unless this one is strictly nearer.
      if (k == 0 || d < best) begin
        best = d;
        win = k;
        tied = 1'b0;
      end else if (d == best) begin
        tied = 1'b1;
      end
    end
    // Saturate the reported distance; the choice above used the full value.
    if (best > DIST_CEIL) best = DIST_CEIL;
    m.pixel = pixel;
    m.idx = IW'(win);
    m.sqdist = BDW'(best);
    return m;
  endfunction

  // Draw a pixel. Four in ten draws are fully random; the rest land near a
  // palette color at some brightness, in the dark range where normalization
  // is coarse, near the gray axis, or with zeroed channels.
  function automatic logic [3*CW-1:0] random_pixel();
    logic [3*CW-1:0] rgb;
    int              chan [3];
    int              scale;
    int              level;
    int              mode;
    mode = $urandom_range(0, 9);
    rgb = SWATCH[$urandom_range(0, NUM_COLORS - 1)];
    scale = $urandom_range(1, 255);
    level = $urandom_range(0, 255);
    for (int c = 0; c < 3; c++) begin
      case (mode)
        4, 5, 6: begin
          chan[c] = (int'(rgb[3*CW-1-CW*c -: CW]) * scale) / 255
                    + $urandom_range(0, 8) - 4;
        end
        7: begin
          chan[c] = $urandom_range(0, 7);
        end
        8: begin
          chan[c] = level + $urandom_range(0, 12) - 6;
        end
        9: begin
          chan[c] = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 255);
        end
        default: begin
          chan[c] = $urandom_range(0, 255);
        end
      endcase
      if (chan[c] < 0) chan[c] = 0;
      if (chan[c] > 255) chan[c] = 255;
    end
    return {CW'(chan[0]), CW'(chan[1]), CW'(chan[2])};
  endfunction

  // Present one pixel and hold it until the block takes the request, then
  // queue the predicted match. Leave start high so a following request can
  // go out on the very next edge.
  task automatic send_pixel(input logic [3*CW-1:0] pixel);
    bit tied;
    color_match_t m;
    start_i <= 1'b1;
    red_i   <= pixel[3*CW-1 -: CW];
    green_i <= pixel[2*CW-1 -: CW];
    blue_i  <= pixel[CW-1 -: CW];
    do @(posedge clk_i); while (busy_o);
    m = nearest_color(pixel, tied);
    pending_matches = {pending_matches, m};
    pixels_sent++;
    if (tied) tie_pixels++;
  endtask

  // Drop start for a random number of cycles: mostly none or a few, now and
  // then a long pause.
  task automatic idle_gap();
    int roll;
    int cycles;
    roll = $urandom_range(0, 99);
    if (roll < 55) cycles = 0;
    else if (roll < 90) cycles = $urandom_range(1, 3);
    else cycles = $urandom_range(8, 40);
    if (cycles > 0) begin
      start_i <= 1'b0;
      repeat (cycles) @(posedge clk_i);
    end
  endtask

  // Hold off until every queued match has come back.
  task automatic wait_for_drain();
    start_i <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk_i);
  endtask

  // Extremes of the channel range, black, white, lone channels and grays.
  task automatic test_corner_pixels();
    logic [3*CW-1:0] corners [12];
    corners = '{24'h000000, 24'hffffff, 24'hff0000, 24'h00ff00, 24'h0000ff,
                24'h010000, 24'h000100, 24'h000001, 24'h010101, 24'h808080,
                24'hfffe01, 24'h01ff80};
    foreach (corners[i]) begin
      send_pixel(corners[i]);
      idle_gap();
    end
  endtask

  // Each palette color itself must win with distance zero.
  task automatic test_palette_entries();
    for (int k = 0; k < NUM_COLORS; k++) send_pixel(SWATCH[k]);
  endtask

  // Hunt for pixels equally near two colors and send the few found.
  task automatic test_tie_break();
    logic [3*CW-1:0] pixel;
    color_match_t    m;
    bit              tied;
    int              found;
    found = 0;
    for (int tries = 0; tries < 20000 && found < 3; tries++) begin
      pixel = random_pixel();
      m = nearest_color(pixel, tied);
      if (tied) begin
        send_pixel(pixel);
        found++;
      end
    end
  endtask

  // Long random stream; every third stretch of forty goes out back to back.
  task automatic test_random_stream(input int count);
    for (int n = 0; n < count; n++) begin
      send_pixel(random_pixel());
      if ((n / 40) % 3 != 2) idle_gap();
    end
  endtask

  // Let the pipeline empty completely, then pick up again from idle.
  task automatic test_drain_then_resume();
    for (int n = 0; n < 30; n++) send_pixel(random_pixel());
    wait_for_drain();
    for (int n = 0; n < 30; n++) begin
      send_pixel(random_pixel());
      idle_gap();
    end
  endtask

  // Compare every strobed result with the oldest prediction.
  always @(posedge clk_i) begin
    color_match_t m;
    if (rst_ni && valid_o) begin
      matches_seen++;
      if (pending_matches.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result: color %0d distance %0d",
                   color_index_o, best_distance_o);
      end else begin
        m = pending_matches.pop_front();
        if (m.idx < NUM_COLORS) color_wins[m.idx]++;
        if (color_index_o !== m.idx || best_distance_o !== m.sqdist) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"Mismatch for pixel %h: expected color %0d distance %0d,",
                      " got color %0d distance %0d"},
                     m.pixel, m.idx, m.sqdist, color_index_o, best_distance_o);
        end
      end
    end
  end

  // Watchdog: stop a hung run long after the slowest correct one would end.
  initial begin
    #5_000_000;
    $display("Timeout: %0d results still outstanding", pending_matches.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    string wins_line;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    red_i   = '0;
    green_i = '0;
    blue_i  = '0;
    pixels_sent = 0;
    matches_seen = 0;
    mismatch_count = 0;
    tie_pixels = 0;
    foreach (color_wins[k]) color_wins[k] = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_corner_pixels();
    test_palette_entries();
    test_tie_break();
    test_random_stream(860);
    test_drain_then_resume();

    // Let the pipeline empty, then watch a little longer for strays.
    wait_for_drain();
    repeat (PIPE_DEPTH + 8) @(posedge clk_i);
    if (pending_matches.size() != 0) mismatch_count += pending_matches.size();

    wins_line = "";
    foreach (color_wins[k]) wins_line = {wins_line, $sformatf(" %0d", color_wins[k])};
    $display("Matched %0d pixels (%0d on a tie between two colors), %0d results checked",
             pixels_sent, tie_pixels, matches_seen);
    $display("Wins per color, red through pink:%s; %0d errors", wins_line, mismatch_count);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- nearest_palette_color.f -----
hdl/npc_pkg.sv
hdl/nearest_palette_color.sv
bench/nearest_palette_color_test.sv
